FILE: rtl/sof_pkg.sv
package sof_pkg;

  localparam int W_OUTER   = 13107;
  localparam int W_INNER   = 19661;
  localparam int FRAC_BITS = 16;
  localparam int ROUND_ADD = 32768;

  localparam logic [3:0] HALF_WINDOW_RESET = 4'd5;
  localparam logic       REG_HALF_WINDOW   = 1'b0;

  typedef struct packed {
    logic shift;
    logic cmp;
    logic cnt;
    logic sum;
    logic mul;
    logic load;
  } sof_cmd_t;

endpackage

FILE: rtl/sof_in_if.sv
interface sof_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_vector;

  modport source (output valid, output sample, output end_of_vector, input ready);
  modport sink (input valid, input sample, input end_of_vector, output ready);
endinterface

FILE: rtl/sof_out_if.sv
interface sof_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          final_of_vector;

  modport source (output valid, output filtered, output final_of_vector, input ready);
  modport sink (input valid, input filtered, input final_of_vector, output ready);
endinterface

FILE: rtl/sliding_order_filter_unit.sv
// channel      dir  payload                          handshake
// sample_ch    in   sample, end_of_vector            valid/ready
// result_ch    out  filtered, final_of_vector        valid/ready
// apb          in   half_window at byte address 0    psel/penable, pready high
//
// one sample per visit to idle; each result scans L window entries, L the window length
// (at most 2h+1), one entry per compare and count step, then sums, multiplies and writes
// an end-of-vector sample produces up to h+1 results back to back before the next sample
// rst is synchronous: counts clear, half_window returns to 5
// a stalled result holds the next result in the write step until taken
module sliding_order_filter_unit
  import sof_pkg::*;
#(
  parameter int HALF_MAX    = 13,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  sof_in_if.sink      sample_ch,
  sof_out_if.source   result_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WIN_DEPTH = 2 * HALF_MAX + 1;
  localparam int CW = $clog2(WIN_DEPTH + 1);
  localparam int IW = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  logic [3:0]    half_window;
  sof_cmd_t      cmd;
  logic [CW-1:0] len;
  logic [IW-1:0] idx;
  logic          final_flag;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HALF_WINDOW) ? {28'd0, half_window} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= HALF_WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_WINDOW) begin
      half_window <= pwdata[3:0];
    end
  end

  sof_ctrl #(.HALF_MAX(HALF_MAX), .WIN_DEPTH(WIN_DEPTH)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(sample_ch.valid), .in_last(sample_ch.end_of_vector),
    .in_ready(sample_ch.ready),
    .out_ready(result_ch.ready), .out_valid(result_ch.valid),
    .half_window(half_window),
    .cmd(cmd), .len(len), .idx(idx), .final_flag(final_flag)
  );

  sof_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .WIN_DEPTH(WIN_DEPTH)) u_dp (
    .clk(clk), .cmd(cmd), .sample(sample_ch.sample),
    .len(len), .idx(idx), .final_in(final_flag),
    .filtered(result_ch.filtered), .final_out(result_ch.final_of_vector)
  );

endmodule

FILE: rtl/sof_datapath.sv
module sof_datapath
  import sof_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int WIN_DEPTH   = 27,
  localparam int CW = $clog2(WIN_DEPTH + 1),
  localparam int IW = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1
) (
  input  logic                          clk,
  input  sof_cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [CW-1:0]          len,
  input  logic        [IW-1:0]          idx,
  input  logic                          final_in,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  output logic                          final_out
);

  localparam int SB = SAMPLE_BITS;
  localparam int SW = SB + 3;
  localparam int PW = SW + 18;
  localparam int RW = PW - FRAC_BITS;
  localparam logic signed [PW-1:0] WO = PW'(W_OUTER);
  localparam logic signed [PW-1:0] WI = PW'(W_INNER);
  localparam logic signed [PW-1:0] RND = PW'(ROUND_ADD);

  logic signed [SB-1:0] win [WIN_DEPTH];
  logic signed [SB-1:0] cand;
  logic signed [SB-1:0] cap [4];
  logic [WIN_DEPTH-1:0] lt;
  logic [WIN_DEPTH-1:0] lt_next;
  logic signed [SB-1:0] cand_sel;
  logic [CW-1:0]        rank;
  logic [CW-1:0]        mid;
  logic signed [SW-1:0] sa, sb, sa_next, sb_next;
  logic signed [SW-1:0] e0, e1, e2, e3;
  logic signed [PW-1:0] pa, pb, acc;
  logic signed [RW-1:0] v;
  logic [RW-SB:0]       top;
  logic signed [SB-1:0] sat;

  assign cand_sel = win[idx];

  always_comb begin
    for (int j = 0; j < WIN_DEPTH; j++) begin
      lt_next[j] = (CW'(j) < len) &&
                   ((win[j] < cand_sel) || ((win[j] == cand_sel) && (IW'(j) < idx)));
    end
  end

  assign rank = CW'($countones(lt));
  assign mid  = len >> 1;

  assign e0 = SW'(cap[0]);
  assign e1 = SW'(cap[1]);
  assign e2 = SW'(cap[2]);
  assign e3 = SW'(cap[3]);

  always_comb begin
    if (len == CW'(2)) begin
      sa_next = e1 + e2 + SW'(1);
      sb_next = '0;
    end else if (len[0]) begin
      sa_next = e1 + e3 + (e2 <<< 1) + e2;
      sb_next = '0;
    end else begin
      sa_next = e0 + e3;
      sb_next = e1 + e2;
    end
  end

  assign acc = pa + pb + RND;

  always_comb begin
    if (len == CW'(1)) begin
      v = RW'(cap[2]);
    end else if (len == CW'(2)) begin
      v = RW'(sa >>> 1);
    end else begin
      v = RW'(acc >>> FRAC_BITS);
    end
  end

  assign top = v[RW-1:SB-1];
  assign sat = ((&top) || !(|top)) ? v[SB-1:0] : {v[RW-1], {(SB-1){~v[RW-1]}}};

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win[0] <= sample;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win[i] <= win[i-1];
      end
    end
    if (cmd.cmp) begin
      lt   <= lt_next;
      cand <= cand_sel;
    end
    if (cmd.cnt) begin
      if (rank == mid - CW'(2)) cap[0] <= cand;
      if (rank == mid - CW'(1)) cap[1] <= cand;
      if (rank == mid)          cap[2] <= cand;
      if (rank == mid + CW'(1)) cap[3] <= cand;
    end
    if (cmd.sum) begin
      sa <= sa_next;
      sb <= sb_next;
    end
    if (cmd.mul) begin
      pa <= PW'(sa) * WO;
      pb <= PW'(sb) * WI;
    end
    if (cmd.load) begin
      filtered  <= sat;
      final_out <= final_in;
    end
  end

endmodule

FILE: rtl/sof_ctrl.sv
module sof_ctrl
  import sof_pkg::*;
#(
  parameter int HALF_MAX  = 13,
  parameter int WIN_DEPTH = 2 * HALF_MAX + 1,
  localparam int CW = $clog2(WIN_DEPTH + 1),
  localparam int IW = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  logic [3:0]    half_window,
  output sof_cmd_t      cmd,
  output logic [CW-1:0] len,
  output logic [IW-1:0] idx,
  output logic          final_flag
);

  typedef enum logic [2:0] {
    S_IDLE, S_PICK, S_CMP, S_CNT, S_SUM, S_MUL, S_WRITE
  } state_t;

  state_t        state;
  logic [CW-1:0] rc, pc, h_q, jrc, flush_d;
  logic          main_pend, last_q;

  logic [CW-1:0] h_cur, rc_n, pc_n, flush_raw, flush_n, twoh1, main_len, flen_raw, flen;
  logic          main_n, accept, write_ok, out_valid_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign write_ok = !out_valid || out_ready;

  assign h_cur     = (int'(half_window) > HALF_MAX) ? CW'(HALF_MAX) : CW'(half_window);
  assign rc_n      = (int'(rc) < WIN_DEPTH) ? rc + CW'(1) : rc;
  assign pc_n      = (int'(pc) < HALF_MAX + 1) ? pc + CW'(1) : pc;
  assign main_n    = (rc_n >= h_cur + CW'(1));
  assign flush_raw = (main_n && pc_n != '0) ? pc_n - CW'(1) : pc_n;
  assign flush_n   = (flush_raw > h_cur) ? h_cur : flush_raw;

  assign twoh1    = (h_q << 1) + CW'(1);
  assign main_len = (jrc < twoh1) ? jrc : twoh1;
  assign flen_raw = flush_d + h_q;
  assign flen     = (flen_raw < jrc) ? flen_raw : jrc;

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (state == S_WRITE && write_ok) out_valid_next = 1'b1;
  end

  always_comb begin
    cmd       = '0;
    cmd.shift = accept;
    cmd.cmp   = (state == S_CMP);
    cmd.cnt   = (state == S_CNT);
    cmd.sum   = (state == S_SUM);
    cmd.mul   = (state == S_MUL);
    cmd.load  = (state == S_WRITE) && write_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rc        <= '0;
      pc        <= '0;
      main_pend <= 1'b0;
      flush_d   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            h_q       <= h_cur;
            jrc       <= rc_n;
            last_q    <= in_last;
            main_pend <= main_n;
            flush_d   <= in_last ? flush_n : '0;
            if (in_last) begin
              rc <= '0;
              pc <= '0;
            end else begin
              rc <= rc_n;
              pc <= (main_n && pc_n != '0) ? pc_n - CW'(1) : pc_n;
            end
            state <= S_PICK;
          end
        end
        S_PICK: begin
          idx <= '0;
          if (main_pend) begin
            main_pend  <= 1'b0;
            len        <= main_len;
            final_flag <= last_q && (flush_d == '0);
            state      <= S_CMP;
          end else if (flush_d != '0) begin
            flush_d    <= flush_d - CW'(1);
            len        <= flen;
            final_flag <= (flush_d == CW'(1));
            state      <= S_CMP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CMP: state <= S_CNT;
        S_CNT: begin
          if (CW'(idx) + CW'(1) == len) begin
            state <= S_SUM;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_CMP;
          end
        end
        S_SUM: state <= S_MUL;
        S_MUL: state <= S_WRITE;
        S_WRITE: begin
          if (write_ok) begin
            state <= S_PICK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sof_checker.sv
module sof_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] filtered,
  input logic                   final_of_vector
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(filtered) && $stable(final_of_vector))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample word taken while previous still in work");

  a_result_not_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result word appeared while idle");

endmodule

bind sliding_order_filter_unit sof_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sof_checker (
  .clk(clk), .rst(rst),
  .in_valid(sample_ch.valid), .in_ready(sample_ch.ready),
  .out_valid(result_ch.valid), .out_ready(result_ch.ready),
  .filtered(result_ch.filtered), .final_of_vector(result_ch.final_of_vector)
);

FILE: tb/sliding_order_filter_unit_tb.sv
module sliding_order_filter_unit_tb
  import sof_pkg::*;
();

  localparam int HMAX  = 13;
  localparam int DEPTH = 2 * HMAX + 1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               eov;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic               fin;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sof_in_if #(.SAMPLE_BITS(16)) sample_ch ();
  sof_out_if #(.SAMPLE_BITS(16)) result_ch ();

  sliding_order_filter_unit dut (
    .clk(clk), .rst(rst), .sample_ch(sample_ch), .result_ch(result_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int   errors = 0;
  bit   no_idle = 1'b0;
  bit   hold_send = 1'b0;
  bit   in_acc = 1'b0;

  logic [3:0] hw_reg;
  logic signed [15:0] win[DEPTH];
  int   rcv_cnt, pend_cnt;

  task automatic report(input string what, input int a, input int b);
    $display("mismatch %s: got %0d want %0d", what, a, b);
    errors++;
  endtask

  function automatic logic signed [15:0] reduce_win(input int len);
    longint s[DEPTH];
    longint v, acc;
    int j, m;
    for (int i = 0; i < len; i++) begin
      v = win[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    if (len == 1) return 16'(s[0]);
    if (len == 2) return 16'((s[0] + s[1] + 1) >>> 1);
    m = len / 2;
    if (len % 2 == 1) acc = W_OUTER * (s[m-1] + s[m+1] + 3 * s[m]);
    else acc = W_OUTER * (s[m-2] + s[m+1]) + W_INNER * (s[m-1] + s[m]);
    acc = (acc + ROUND_ADD) >>> FRAC_BITS;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return 16'(acc);
  endfunction

  task automatic predict(input in_word_t w);
    int h, flush, len;
    out_word_t r;
    h = (hw_reg > HMAX) ? HMAX : hw_reg;
    for (int i = DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = w.sample;
    if (rcv_cnt < DEPTH) rcv_cnt++;
    if (pend_cnt < HMAX + 1) pend_cnt++;
    flush = 0;
    if (w.eov) begin
      flush = pend_cnt;
      if (rcv_cnt >= h + 1 && flush > 0) flush--;
      if (flush > h) flush = h;
    end
    if (rcv_cnt >= h + 1) begin
      len = (rcv_cnt > 2 * h + 1) ? 2 * h + 1 : rcv_cnt;
      r.filtered = reduce_win(len);
      r.fin = w.eov && flush == 0;
      expected_words.push_back(r);
      if (pend_cnt > 0) pend_cnt--;
    end
    if (w.eov) begin
      for (int d = flush; d > 0; d--) begin
        len = d + h;
        if (len > rcv_cnt) len = rcv_cnt;
        r.filtered = reduce_win(len);
        r.fin = (d == 1);
        expected_words.push_back(r);
      end
      rcv_cnt = 0;
      pend_cnt = 0;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (sample_ch.valid && !in_acc) begin
    end else if (pending_words.size() > 0 && !hold_send &&
                 (no_idle || $urandom_range(99) >= 27)) begin
      sample_ch.valid <= 1'b1;
      sample_ch.sample <= pending_words[0].sample;
      sample_ch.end_of_vector <= pending_words[0].eov;
      void'(pending_words.pop_front());
    end else begin
      sample_ch.valid <= 1'b0;
    end
    result_ch.ready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    in_acc = !rst && sample_ch.valid && sample_ch.ready;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      predict('{sample_ch.sample, sample_ch.end_of_vector});
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", result_ch.filtered, 0);
      end else begin
        if (result_ch.filtered !== expected_words[0].filtered)
          report("filtered", result_ch.filtered, expected_words[0].filtered);
        if (result_ch.final_of_vector !== expected_words[0].fin)
          report("final_of_vector", result_ch.final_of_vector, expected_words[0].fin);
        void'(expected_words.pop_front());
      end
    end
  end

  task automatic apb_write(input logic [3:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {28'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    hw_reg = v;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || sample_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_vec(input int n, input bit extreme);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      if (extreme) w.sample = ($urandom_range(1) ? 16'sh7fff : 16'sh8000);
      else if ($urandom_range(9) == 0) w.sample = 16'($urandom_range(3) - 2);
      else w.sample = 16'($urandom);
      w.eov = (i == n - 1);
      pending_words.push_back(w);
    end
  endtask

  initial begin
    int hsel[6];
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    sample_ch.end_of_vector = 1'b0;
    result_ch.ready = 1'b0;
    hw_reg = HALF_WINDOW_RESET;
    rcv_cnt = 0;
    pend_cnt = 0;
    for (int i = 0; i < DEPTH; i++) win[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push_vec(8, 1'b1);
    push_vec(3, 1'b0);
    push_vec(1, 1'b0);
    drain();
    apb_write(4'd0);
    push_vec(4, 1'b0);
    drain();
    apb_write(4'd1);
    push_vec(2, 1'b1);
    push_vec(4, 1'b0);
    drain();
    apb_write(4'd15);
    push_vec(3, 1'b0);
    drain();

    hsel = '{2, 13, 3, 0, 7, 1};
    foreach (hsel[k]) begin
      apb_write(4'(hsel[k]));
      no_idle = (k == 2);
      for (int v = 0; v < 3; v++) push_vec($urandom_range(1, (hsel[k] > 6) ? 10 : 6), 1'b0);
      if (k == 4) begin
        hold_send = 1'b1;
        while (expected_words.size() > 0 || sample_ch.valid) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end
    no_idle = 1'b0;
    apb_write(4'd4);
    push_vec(9, 1'b0);
    pending_words[$].eov = 1'b0;
    // mid-vector change of the half window
    drain();
    apb_write(4'd14);
    push_vec(6, 1'b0);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: files.f
rtl/sof_pkg.sv
rtl/sof_in_if.sv
rtl/sof_out_if.sv
rtl/sof_datapath.sv
rtl/sof_ctrl.sv
rtl/sliding_order_filter_unit.sv
rtl/sof_checker.sv
tb/sliding_order_filter_unit_tb.sv
